/* sv/onewire_bus_master_unit_defines.svh */
// Assertion macros for the onewire bus master unit.
// Used by obm_engine, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef ONEWIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define OBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the same cycle.
`define OBM_ASSERT_IMPL(label, ante, cons, msg) \
    `OBM_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* sv/obm_pkg.sv */
// Shared types, codes, constants and helpers for the onewire bus master unit.
// No dependencies.
`timescale 1ns / 1ps

package obm_pkg;

    localparam int TIME_W     = 10;
    localparam int SLOT_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Depth of the queue between front and engine; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVER  = 3'd7;

    // Register defaults after reset
    localparam logic [TIME_W-1:0] DEF_RESET_LOW     = 10'd480;
    localparam logic [TIME_W-1:0] DEF_PRESENCE_WAIT = 10'd60;
    localparam logic [TIME_W-1:0] DEF_RESET_RECOVER = 10'd240;
    localparam logic [SLOT_W-1:0] DEF_WRITE_SLOT    = 8'd60;
    localparam logic [SLOT_W-1:0] DEF_WRITE_ONE_LOW = 8'd2;
    localparam logic [SLOT_W-1:0] DEF_READ_LOW      = 8'd1;
    localparam logic [SLOT_W-1:0] DEF_READ_SAMPLE   = 8'd15;
    localparam logic [SLOT_W-1:0] DEF_READ_RECOVER  = 8'd105;

    // Released gap after the last bit of a written byte
    localparam logic [TIME_W-1:0] WR_GAP_US = 10'd100;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  write_value;
        logic        line_level;
    } t_item;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence;
        logic [7:0]  read_value;
        logic        rejected;
    } t_result;

    // Zero in a time register given to these helpers counts as one microsecond.
    function automatic logic [TIME_W-1:0] f_min1_10(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic logic [TIME_W-1:0] f_min1_8(input logic [SLOT_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : {{(TIME_W-SLOT_W){1'b0}}, v};
    endfunction

endpackage

/* sv/obm_if.sv */
// Valid/ready channel interfaces for command input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface obm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  write_value;
    logic        line_level;

    modport source (output valid, output op, output write_value, output line_level,
                    input ready);
    modport sink   (input valid, input op, input write_value, input line_level,
                    output ready);
endinterface

interface obm_rsp_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [7:0]  read_value;
    logic        rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_value, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_value, input rejected, output ready);
endinterface

/* sv/obm_front.sv */
// Front stage: takes request transfers, decodes the op into an item kind, registers it.
// Depends on obm_pkg and obm_req_if.
`timescale 1ns / 1ps

module obm_front import obm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    obm_req_if.sink i_req,
    output logic    o_q_valid,
    input  logic    i_q_ready,
    output t_item   o_q_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_req.ready = !r_valid || i_q_ready;

    always_comb begin
        n_item.write_value = i_req.write_value;
        n_item.line_level  = i_req.line_level;
        unique case (i_req.op)
            OP_TICK:  n_item.kind = KIND_TICK;
            OP_RESET: n_item.kind = KIND_RESET;
            OP_WRITE: n_item.kind = KIND_WRITE;
            OP_READ:  n_item.kind = KIND_READ;
            default:  n_item.kind = KIND_TICK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= n_item;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

/* sv/obm_fifo.sv */
// Short queue between the front stage and the bus engine.
// Depends on obm_pkg.
`timescale 1ns / 1ps

module obm_fifo import obm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_pop_item = r_mem[r_rd_ptr];

endmodule

/* sv/obm_engine.sv */
// Bus engine: timing registers, phase sequencer, shift register and result register.
// Depends on obm_pkg, obm_rsp_if and the assertion macros header.
`timescale 1ns / 1ps
`include "onewire_bus_master_unit_defines.svh"

module obm_engine import obm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  t_item                 i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    obm_rsp_if.source             o_rsp
);

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_RST_WAIT = 10'b00_0000_0100,
        PH_RST_REC  = 10'b00_0000_1000,
        PH_WR_LOW   = 10'b00_0001_0000,
        PH_WR_REL   = 10'b00_0010_0000,
        PH_WR_GAP   = 10'b00_0100_0000,
        PH_RD_LOW   = 10'b00_1000_0000,
        PH_RD_WAIT  = 10'b01_0000_0000,
        PH_RD_REC   = 10'b10_0000_0000
    } t_phase;

    // timing registers
    logic [TIME_W-1:0] r_reset_low;
    logic [TIME_W-1:0] r_presence_wait;
    logic [TIME_W-1:0] r_reset_recover;
    logic [SLOT_W-1:0] r_write_slot;
    logic [SLOT_W-1:0] r_write_one_low;
    logic [SLOT_W-1:0] r_read_low;
    logic [SLOT_W-1:0] r_read_sample;
    logic [SLOT_W-1:0] r_read_recover;

    t_phase            r_phase,     n_phase;
    logic [TIME_W-1:0] r_time_left, n_time_left;
    logic [2:0]        r_bit_index, n_bit_index;
    logic [7:0]        r_shift,     n_shift;
    logic              r_presence,  n_presence;
    logic [7:0]        r_last_read, n_last_read;

    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              pop;

    assign o_item_ready = !r_out_valid || o_rsp.ready;
    assign pop          = i_item_valid && o_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= DEF_RESET_LOW;
            r_presence_wait <= DEF_PRESENCE_WAIT;
            r_reset_recover <= DEF_RESET_RECOVER;
            r_write_slot    <= DEF_WRITE_SLOT;
            r_write_one_low <= DEF_WRITE_ONE_LOW;
            r_read_low      <= DEF_READ_LOW;
            r_read_sample   <= DEF_READ_SAMPLE;
            r_read_recover  <= DEF_READ_RECOVER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data;
                CFG_RESET_RECOVER: r_reset_recover <= i_cfg_data;
                CFG_WRITE_SLOT:    r_write_slot    <= i_cfg_data[SLOT_W-1:0];
                CFG_WRITE_ONE_LOW: r_write_one_low <= i_cfg_data[SLOT_W-1:0];
                CFG_READ_LOW:      r_read_low      <= i_cfg_data[SLOT_W-1:0];
                CFG_READ_SAMPLE:   r_read_sample   <= i_cfg_data[SLOT_W-1:0];
                CFG_READ_RECOVER:  r_read_recover  <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [7:0]        sb;
        logic [7:0]        sb_next;
        logic [TIME_W-1:0] tl_dec;
        logic              done;
        logic              rejected;

        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        done        = 1'b0;
        rejected    = 1'b0;
        sb          = r_shift;
        sb_next     = {1'b0, r_shift[7:1]};
        tl_dec      = r_time_left - 1'b1;

        if (i_item.kind != KIND_TICK) begin
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_bit_index = '0;
                unique case (i_item.kind)
                    KIND_RESET: begin
                        n_phase     = PH_RST_LOW;
                        n_time_left = f_min1_10(r_reset_low);
                    end
                    KIND_WRITE: begin
                        n_shift     = i_item.write_value;
                        n_phase     = PH_WR_LOW;
                        n_time_left = i_item.write_value[0] ? f_min1_8(r_write_one_low)
                                                            : f_min1_8(r_write_slot);
                    end
                    default: begin
                        n_shift     = '0;
                        n_phase     = PH_RD_LOW;
                        n_time_left = f_min1_8(r_read_low);
                    end
                endcase
            end
        end else if (r_phase != PH_IDLE) begin
            // sample on the last tick of a wait
            if (r_time_left == TIME_W'(1)) begin
                if (r_phase == PH_RST_WAIT) n_presence = !i_item.line_level;
                if (r_phase == PH_RD_WAIT)  sb = {i_item.line_level, r_shift[7:1]};
            end
            n_shift = sb;
            if (tl_dec != '0) begin
                n_time_left = tl_dec;
            end else begin
                unique case (r_phase)
                    PH_RST_LOW: begin
                        n_phase     = PH_RST_WAIT;
                        n_time_left = f_min1_10(r_presence_wait);
                    end
                    PH_RST_WAIT: begin
                        if (r_reset_recover == '0) begin
                            n_phase     = PH_IDLE;
                            n_time_left = '0;
                            done        = 1'b1;
                        end else begin
                            n_phase     = PH_RST_REC;
                            n_time_left = r_reset_recover;
                        end
                    end
                    PH_WR_LOW: begin
                        n_phase     = PH_WR_REL;
                        n_time_left = sb[0] ? f_min1_8(r_write_slot) : TIME_W'(1);
                    end
                    PH_WR_REL: begin
                        if (r_bit_index == 3'd7) begin
                            n_phase     = PH_WR_GAP;
                            n_time_left = WR_GAP_US;
                        end else begin
                            n_bit_index = r_bit_index + 1'b1;
                            n_shift     = sb_next;
                            n_phase     = PH_WR_LOW;
                            n_time_left = sb_next[0] ? f_min1_8(r_write_one_low)
                                                     : f_min1_8(r_write_slot);
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase     = PH_RD_WAIT;
                        n_time_left = f_min1_8(r_read_sample);
                    end
                    PH_RD_WAIT, PH_RD_REC: begin
                        if (r_phase == PH_RD_WAIT && r_read_recover != '0) begin
                            n_phase     = PH_RD_REC;
                            n_time_left = {{(TIME_W-SLOT_W){1'b0}}, r_read_recover};
                        end else if (r_bit_index == 3'd7) begin
                            // recovery over (or skipped) after the last bit
                            n_last_read = sb;
                            n_phase     = PH_IDLE;
                            n_time_left = '0;
                            done        = 1'b1;
                        end else begin
                            n_bit_index = r_bit_index + 1'b1;
                            n_phase     = PH_RD_LOW;
                            n_time_left = f_min1_8(r_read_low);
                        end
                    end
                    default: begin
                        // reset recovery and write gap end the sequence
                        n_phase     = PH_IDLE;
                        n_time_left = '0;
                        done        = 1'b1;
                    end
                endcase
            end
        end

        n_out.drive_low  = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                           (n_phase == PH_RD_LOW);
        n_out.busy_res   = (n_phase != PH_IDLE);
        n_out.done_res   = done;
        n_out.presence   = n_presence;
        n_out.read_value = n_last_read;
        n_out.rejected   = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else if (pop) begin
            r_phase     <= n_phase;
            r_time_left <= n_time_left;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_item_ready) begin
            r_out_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.drive_low  = r_out.drive_low;
    assign o_rsp.busy_res   = r_out.busy_res;
    assign o_rsp.done_res   = r_out.done_res;
    assign o_rsp.presence   = r_out.presence;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.rejected   = r_out.rejected;

    // a running phase always has ticks left; idle never does
    `OBM_ASSERT(a_idle_means_no_time, (r_phase == PH_IDLE) == (r_time_left == '0), "time_left out of step with phase")
    `OBM_ASSERT_IMPL(a_done_not_rejected, r_out_valid, !(r_out.done_res && r_out.rejected), "done and rejected together")
    `OBM_ASSERT_IMPL(a_done_goes_idle, r_out_valid && r_out.done_res, !r_out.busy_res && !r_out.drive_low, "done while still busy")
    `OBM_ASSERT_IMPL(a_reject_only_busy, pop && (i_item.kind != KIND_TICK) && (r_phase == PH_IDLE), !n_out.rejected && n_out.busy_res, "command from idle not started")

endmodule

/* sv/onewire_bus_master_unit.sv */
// Top level of the onewire bus master unit: front stage, queue and bus engine.
// Depends on obm_pkg, obm_req_if/obm_rsp_if, obm_front, obm_fifo and obm_engine.
`timescale 1ns / 1ps

// Timed 1-Wire bus master. Every request transfer (a one-microsecond tick or a
// reset / write byte / read byte command) yields exactly one result transfer
// carrying the bus drive, busy, done, presence, last read byte and a rejected
// flag for commands sent while a sequence is still running. The unit sustains
// one item per clock unless the result channel stalls: the engine settles each
// item's phase update, including skipped zero-length recovery phases, as it
// takes the item, and a two-entry queue plus registered front and output stages
// hold items while the result channel stalls. Each item passes the front register,
// the queue and the output register before its result is valid. Timing registers
// must be written by the user through the plain configuration port while the unit
// is idle; the block does not enforce this. No clearing pass follows reset.
module onewire_bus_master_unit import obm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    obm_req_if.sink               i_req,
    obm_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    obm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (front_valid),
        .i_q_ready (front_ready),
        .o_q_item  (front_item)
    );

    obm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    obm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_rsp        (o_rsp)
    );

endmodule
